/* src/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and helpers of the keypad tap/hold scanner.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int KEY_COUNT   = 30;
    localparam int LAYER_COUNT = 6;
    localparam int KEY_W       = 5;
    localparam int LAYER_W     = 3;
    localparam int CNT_W       = 16;
    localparam int TICK_W      = 10;
    localparam int REM_W       = 10;
    localparam int BIT_SEL_W   = 4;
    localparam int CFG_W       = 60;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = KEY_W * LAYER_COUNT;
    localparam int LIM_W       = TICK_W * LAYER_COUNT;

    localparam logic signed [CNT_W-1:0] HOLD_MAX = 16'sd32767;
    // highest magnitude bit of a non-negative counter
    localparam logic [BIT_SEL_W-1:0] MOD_TOP = 4'd14;

    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 10'd20;
    localparam logic [TICK_W-1:0] CANCEL_RST   = 10'd500;
    localparam logic [TICK_W-1:0] DELAY_RST    = 10'd500;
    localparam logic [TICK_W-1:0] REPEAT_RST   = 10'd50;
    localparam logic [LIM_W-1:0]  LAYER_HOLD_RST = 60'd225400098652365000;
    localparam logic [POS_W-1:0]  LAYER_POS_RST  = 30'd172066848;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_CANCEL     = 3'd1,
        CFG_DELAY      = 3'd2,
        CFG_REPEAT     = 3'd3,
        CFG_LAYER_HOLD = 3'd4,
        CFG_LAYER_POS  = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_LAYER,
        ST_CLIP,
        ST_MOD,
        ST_FIRE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        LN_HOLD,
        LN_UPD,
        LN_CLIP,
        LN_MOD
    } lane_op_t;

    typedef struct packed {
        lane_op_t                op;
        logic [TICK_W-1:0]       deb;
        logic [TICK_W-1:0]       limit;
        logic [TICK_W-1:0]       hold_limit;
        logic [TICK_W-1:0]       delay;
        logic [TICK_W-1:0]       rtk;
        logic [TICK_W-1:0]       cancel;
        logic [CNT_W-1:0]        clip_val;
        logic [BIT_SEL_W-1:0]    bit_sel;
    } lane_ctrl_t;

    function automatic logic [KEY_W-1:0] layer_pos(input logic [POS_W-1:0] word,
                                                   input logic [LAYER_W-1:0] i);
        return word[KEY_W*i +: KEY_W];
    endfunction

    function automatic logic [TICK_W-1:0] layer_limit(input logic [LIM_W-1:0] word,
                                                      input logic [LAYER_W-1:0] i);
        return word[TICK_W*i +: TICK_W];
    endfunction

endpackage

/* src/kts_lane.sv */
// ----------------------------------------------------------------------------
// kts_lane
// One key lane: held-time counter, clip, bit-serial remainder and fire test.
// ----------------------------------------------------------------------------
module kts_lane
    import kts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctrl_t              ctrl,
    input  logic                    key_bit,
    input  logic                    skip,
    input  logic                    zero_en,
    input  logic                    set_en,
    output logic signed [CNT_W-1:0] count,
    output logic                    fire
);

    logic signed [CNT_W-1:0] count_reg, count_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [REM_W-1:0]        rem_base;
    logic [REM_W:0]          rem_shift;
    logic signed [17:0]      h_ext, mag, deb_s, lim_s, lim_dly, hold_s;
    logic                    fire_neg, fire_pos;

    // counter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // remainder register
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    // one restoring step of count mod repeat period
    always_comb
    begin
        rem_base  = (ctrl.bit_sel == MOD_TOP) ? '0 : rem_reg;
        rem_shift = {rem_base, count_reg[ctrl.bit_sel]};
        if (rem_shift >= {1'b0, ctrl.rtk})
        begin
            rem_shift = rem_shift - {1'b0, ctrl.rtk};
        end
        rem_next = (ctrl.op == LN_MOD) ? rem_shift[REM_W-1:0] : rem_reg;
    end

    // signed compares
    always_comb
    begin
        h_ext   = 18'(count_reg);
        mag     = -h_ext;
        deb_s   = 18'($signed({8'd0, ctrl.deb}));
        lim_s   = 18'($signed({8'd0, ctrl.limit}));
        hold_s  = 18'($signed({8'd0, ctrl.hold_limit}));
        lim_dly = lim_s + 18'($signed({8'd0, ctrl.delay}));
        fire_neg = (mag > deb_s) && (mag < lim_s);
        fire_pos = (h_ext == lim_s) ||
                   ((ctrl.rtk != '0) && (h_ext > lim_dly) && (rem_reg == '0));
        fire     = !skip && (count_reg[CNT_W-1] ? fire_neg : fire_pos);
    end

    // next counter value
    always_comb
    begin
        count_next = count_reg;
        if (set_en)
        begin
            count_next = CNT_W'($signed({6'd0, ctrl.cancel}));
        end
        else if (zero_en)
        begin
            count_next = '0;
        end
        else
        begin
            case (ctrl.op)
                LN_UPD:
                begin
                    if (!count_reg[CNT_W-1])
                    begin
                        if (key_bit)
                        begin
                            if (count_reg < HOLD_MAX)
                            begin
                                count_next = count_reg + 16'sd1;
                            end
                        end
                        else
                        begin
                            count_next = -count_reg;
                        end
                    end
                end
                LN_CLIP:
                begin
                    if ((h_ext > deb_s - 18'sd1) && (h_ext <= hold_s))
                    begin
                        count_next = ctrl.clip_val;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign count = count_reg;

endmodule

/* src/kts_merge.sv */
// ----------------------------------------------------------------------------
// kts_merge
// Merging stage: picks the lowest-numbered lane that fires.
// ----------------------------------------------------------------------------
module kts_merge
    import kts_pkg::*;
(
    input  logic [KEY_COUNT-1:0] fire_vec,
    output logic                 found,
    output logic [KEY_W-1:0]     first
);

    // priority encode, lowest index wins
    always_comb
    begin
        found = 1'b0;
        first = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (fire_vec[k])
            begin
                found = 1'b1;
                first = KEY_W'(k);
            end
        end
    end

endmodule

/* src/keypad_tap_hold_scanner.sv */
// ----------------------------------------------------------------------------
// keypad_tap_hold_scanner
// Tap/hold matrix scanner with debounce, dual-role layer keys and repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one full matrix scan as
//   key_bits. Output channel (out_valid / out_stall) returns exactly one
//   item per scan: event_valid, key_index and layer (all zero when the
//   scan produced no event).
//   Each scan runs from acceptance to out_valid through a counter update,
//   a layer decision, an optional clip step (when a layer-key release
//   clips the held keys; a tap release ends there and goes straight to
//   the output register), bit-serial remainder steps running in all 30
//   key lanes at once, a merge step and the load of the output register.
//   The block returns to idle before the next acceptance; one scan is
//   worked at a time.
//   in_stall is high from acceptance until the result is loaded into the
//   output register. If the receiver stalls, the result stays on the
//   output ports and the block waits before taking the next scan.
//   Reset clears all counters and the active layer and loads the register
//   defaults; configuration writes go through cfg_wen / cfg_index /
//   cfg_wdata at any time the block is idle.
// ----------------------------------------------------------------------------
module keypad_tap_hold_scanner
    import kts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KEY_COUNT-1:0]  key_bits,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  event_valid,
    output logic [KEY_W-1:0]      key_index,
    output logic [LAYER_W-1:0]    layer
);

    // configuration registers
    logic [TICK_W-1:0] deb_reg, cancel_reg, delay_reg, rtk_reg;
    logic [LIM_W-1:0]  hold_word_reg;
    logic [POS_W-1:0]  pos_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg       <= DEBOUNCE_RST;
            cancel_reg    <= CANCEL_RST;
            delay_reg     <= DELAY_RST;
            rtk_reg       <= REPEAT_RST;
            hold_word_reg <= LAYER_HOLD_RST;
            pos_word_reg  <= LAYER_POS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:   deb_reg       <= cfg_wdata[TICK_W-1:0];
                CFG_CANCEL:     cancel_reg    <= cfg_wdata[TICK_W-1:0];
                CFG_DELAY:      delay_reg     <= cfg_wdata[TICK_W-1:0];
                CFG_REPEAT:     rtk_reg       <= cfg_wdata[TICK_W-1:0];
                CFG_LAYER_HOLD: hold_word_reg <= cfg_wdata[LIM_W-1:0];
                CFG_LAYER_POS:  pos_word_reg  <= cfg_wdata[POS_W-1:0];
                default:        deb_reg       <= deb_reg;
            endcase
        end
    end

    // control and scan state
    state_t                 state_reg, state_next;
    logic [KEY_COUNT-1:0]   bits_reg, bits_next;
    logic [LAYER_W-1:0]     layer_reg, layer_next;
    logic [TICK_W-1:0]      limit_reg, limit_next;
    logic [KEY_W-1:0]       spos_reg, spos_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic [BIT_SEL_W-1:0]   bit_reg, bit_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   ev_reg, ev_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [LAYER_W-1:0]     lay_reg, lay_next;
    logic                   res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]       res_key_reg, res_key_next;
    logic [LAYER_W-1:0]     res_lay_reg, res_lay_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            layer_reg     <= '0;
            limit_reg     <= DEBOUNCE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg    <= bits_next;
        spos_reg    <= spos_next;
        held_reg    <= held_next;
        bit_reg     <= bit_next;
        ev_reg      <= ev_next;
        key_reg     <= key_next;
        lay_reg     <= lay_next;
        res_ev_reg  <= res_ev_next;
        res_key_reg <= res_key_next;
        res_lay_reg <= res_lay_next;
    end

    // key lanes
    lane_ctrl_t              ctrl;
    lane_op_t                lane_op;
    logic signed [CNT_W-1:0] lane_count [KEY_COUNT];
    logic [KEY_COUNT-1:0]    neg_vec, eqdeb_vec, fire_vec, skip_vec;
    logic [KEY_COUNT-1:0]    zero_vec, set_vec;
    logic                    found;
    logic [KEY_W-1:0]        first;

    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        kts_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .key_bit (bits_reg[k]),
            .skip    (skip_vec[k]),
            .zero_en (zero_vec[k]),
            .set_en  (set_vec[k]),
            .count   (lane_count[k]),
            .fire    (fire_vec[k])
        );
        assign neg_vec[k]   = lane_count[k][CNT_W-1];
        assign eqdeb_vec[k] = (lane_count[k] == CNT_W'($signed({6'd0, deb_reg})));
        assign skip_vec[k]  = (layer_reg != '0) && (spos_reg == KEY_W'(k));
    end

    kts_merge u_merge (
        .fire_vec (fire_vec),
        .found    (found),
        .first    (first)
    );

    // layer decision helpers
    logic [KEY_W-1:0]   cur_pos;
    logic               drop;
    logic               sel_found;
    logic [LAYER_W-1:0] sel_layer;
    logic [TICK_W-1:0]  sel_limit;
    logic [KEY_W-1:0]   sel_pos;
    logic [KEY_W-1:0]   cand;

    always_comb
    begin
        cur_pos   = layer_pos(pos_word_reg, layer_reg - LAYER_W'(1));
        drop      = (layer_reg != '0) && (cur_pos >= KEY_W'(KEY_COUNT));
        sel_found = 1'b0;
        sel_layer = '0;
        sel_limit = '0;
        sel_pos   = '0;
        for (int i = LAYER_COUNT - 1; i >= 0; i--)
        begin
            cand = layer_pos(pos_word_reg, LAYER_W'(i));
            if ((cand < KEY_W'(KEY_COUNT)) && eqdeb_vec[cand])
            begin
                sel_found = 1'b1;
                sel_layer = LAYER_W'(i + 1);
                sel_limit = layer_limit(hold_word_reg, LAYER_W'(i));
                sel_pos   = cand;
            end
        end
    end

    // lane control shared fields
    always_comb
    begin
        ctrl.op         = lane_op;
        ctrl.deb        = deb_reg;
        ctrl.limit      = (layer_reg != '0) ? limit_reg : deb_reg;
        ctrl.hold_limit = limit_reg;
        ctrl.delay      = delay_reg;
        ctrl.rtk        = rtk_reg;
        ctrl.cancel     = cancel_reg;
        ctrl.clip_val   = (deb_reg != '0) ? CNT_W'(deb_reg - TICK_W'(1)) : '0;
        ctrl.bit_sel    = bit_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        layer_next     = layer_reg;
        limit_next     = limit_reg;
        spos_next      = spos_reg;
        held_next      = held_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        ev_next        = ev_reg;
        key_next       = key_reg;
        lay_next       = lay_reg;
        res_ev_next    = res_ev_reg;
        res_key_next   = res_key_reg;
        res_lay_next   = res_lay_reg;
        lane_op        = LN_HOLD;
        zero_vec       = '0;
        set_vec        = '0;
        in_stall       = 1'b1;

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    bits_next  = key_bits;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                lane_op    = LN_UPD;
                state_next = ST_LAYER;
            end
            ST_LAYER:
            begin
                bit_next = MOD_TOP;
                if ((layer_reg == '0) || drop)
                begin
                    layer_next = '0;
                    if (sel_found)
                    begin
                        layer_next = sel_layer;
                        limit_next = sel_limit;
                        spos_next  = sel_pos;
                    end
                    state_next = ST_MOD;
                end
                else
                begin
                    spos_next = cur_pos;
                    if (neg_vec[cur_pos])
                    begin
                        held_next  = CNT_W'(-lane_count[cur_pos]);
                        state_next = ST_CLIP;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_CLIP:
            begin
                lane_op            = LN_CLIP;
                zero_vec[spos_reg] = 1'b1;
                layer_next         = '0;
                limit_next         = deb_reg;
                if (held_reg < CNT_W'(cancel_reg))
                begin
                    res_ev_next  = 1'b1;
                    res_key_next = spos_reg;
                    res_lay_next = '0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                lane_op  = LN_MOD;
                bit_next = bit_reg - BIT_SEL_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    zero_vec[k] = neg_vec[k] && !skip_vec[k] &&
                                  (!found || (KEY_W'(k) <= first));
                end
                if (found && (layer_reg != '0))
                begin
                    set_vec[spos_reg] = 1'b1;
                end
                res_ev_next  = found;
                res_key_next = found ? first : '0;
                res_lay_next = found ? layer_reg : '0;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = res_ev_reg;
                    key_next       = res_key_reg;
                    lay_next       = res_lay_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_reg;
    assign key_index   = key_reg;
    assign layer       = lay_reg;

endmodule

/* src/kts_checker.sv */
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks of the keypad tap/hold scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker
    import kts_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 event_valid,
    input logic [KEY_W-1:0]     key_index,
    input logic [LAYER_W-1:0]   layer
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_index) && $stable(layer)
                                   && $stable(event_valid))
        else $error("stalled result changed");

    // one scan at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("scan accepted while busy");

    // an empty result carries zeros
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> (key_index == '0) && (layer == '0))
        else $error("empty result not zero");

    // reported key and layer stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (layer <= LAYER_W'(LAYER_COUNT)) && (key_index < KEY_W'(KEY_COUNT)))
        else $error("result out of range");

endmodule

bind keypad_tap_hold_scanner kts_checker u_kts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_valid (event_valid),
    .key_index   (key_index),
    .layer       (layer)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad tap/hold scanner: a table of directed
// scans, then random scan sequences, checked against a scan predictor or a typed result.
// ----------------------------------------------------------------------------
module testbench;
    import kts_pkg::*;

    typedef struct packed {
        logic             ev;
        logic [KEY_W-1:0] key;
        logic [LAYER_W-1:0] lay;
    } key_event_t;

    typedef struct {
        logic [KEY_COUNT-1:0] bits;
        logic                 typed;
        key_event_t           ev;
    } scan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [KEY_COUNT-1:0] key_bits;
    logic                 out_valid;
    logic                 out_stall;
    logic                 event_valid;
    logic [KEY_W-1:0]     key_index;
    logic [LAYER_W-1:0]   layer;

    // predictor state
    int          held_cnt [KEY_COUNT];
    int unsigned cur_layer;
    int          cur_limit;
    int unsigned p_deb, p_cancel, p_delay, p_repeat;
    logic [LIM_W-1:0] p_hold;
    logic [POS_W-1:0] p_pos;

    key_event_t  pending_events[$];
    key_event_t  typed_events[$];
    logic        typed_flags[$];
    int          failures;
    int          idle_cycles;
    int          rx_phase;

    keypad_tap_hold_scanner i_dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic key_event_t fire_event(int unsigned k, int unsigned l);
        key_event_t e;
        e.ev  = 1'b1;
        e.key = k[KEY_W-1:0];
        e.lay = l[LAYER_W-1:0];
        return e;
    endfunction

    // one scan through the predictor
    function automatic key_event_t predict_scan(logic [KEY_COUNT-1:0] bits);
        key_event_t  none;
        int          deb;
        int unsigned spos;
        int unsigned p;
        int          held, clip, lim, h;
        logic        fire;
        none = '0;
        deb  = int'(p_deb);
        spos = 0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (held_cnt[k] >= 0)
            begin
                if (bits[k])
                begin
                    if (held_cnt[k] < 32767)
                        held_cnt[k]++;
                end
                else
                    held_cnt[k] = -held_cnt[k];
            end
        end
        if (cur_layer != 0)
        begin
            spos = p_pos[KEY_W*(cur_layer-1) +: KEY_W];
            if (spos >= KEY_COUNT)
                cur_layer = 0;
        end
        if (cur_layer == 0)
        begin
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                p = p_pos[KEY_W*i +: KEY_W];
                if (p < KEY_COUNT && held_cnt[p] == deb)
                begin
                    cur_layer = i + 1;
                    cur_limit = int'(p_hold[TICK_W*i +: TICK_W]);
                    spos = p;
                    break;
                end
            end
        end
        else if (held_cnt[spos] < 0)
        begin
            held = -held_cnt[spos];
            clip = deb > 0 ? deb - 1 : 0;
            for (int k = 0; k < KEY_COUNT; k++)
                if (held_cnt[k] > deb - 1 && held_cnt[k] <= cur_limit)
                    held_cnt[k] = clip;
            cur_layer = 0;
            cur_limit = deb;
            held_cnt[spos] = 0;
            if (held < int'(p_cancel))
                return fire_event(spos, 0);
        end
        lim = cur_layer != 0 ? cur_limit : deb;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            h = held_cnt[k];
            if (cur_layer != 0 && k == spos)
                continue;
            if (h < 0)
            begin
                h = -h;
                held_cnt[k] = 0;
                fire = h > deb && h < lim;
            end
            else
                fire = (h == lim) || (p_repeat != 0 && h > lim + int'(p_delay)
                                      && (h % int'(p_repeat)) == 0);
            if (fire)
            begin
                if (cur_layer != 0)
                    held_cnt[spos] = int'(p_cancel);
                return fire_event(k, cur_layer);
            end
        end
        return none;
    endfunction

    // register write, block idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:   p_deb    = 32'(val[TICK_W-1:0]);
            CFG_CANCEL:     p_cancel = 32'(val[TICK_W-1:0]);
            CFG_DELAY:      p_delay  = 32'(val[TICK_W-1:0]);
            CFG_REPEAT:     p_repeat = 32'(val[TICK_W-1:0]);
            CFG_LAYER_HOLD: p_hold   = val[LIM_W-1:0];
            CFG_LAYER_POS:  p_pos    = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // send one scan; typed expectation used when given
    task automatic send_scan(logic [KEY_COUNT-1:0] bits, logic typed, key_event_t ev);
        key_event_t e;
        in_valid <= 1'b1;
        key_bits <= bits;
        do
            @(posedge clk);
        while (in_stall);
        e = predict_scan(bits);
        pending_events.push_back(e);
        typed_flags.push_back(typed);
        typed_events.push_back(ev);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    // receiver stall pattern and checking
    always @(posedge clk)
    begin
        key_event_t want, typ;
        logic       tf;
        if (rst_n)
        begin
            rx_phase <= rx_phase + 1;
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("event with no scan pending");
                    failures++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    tf   = typed_flags.pop_front();
                    typ  = typed_events.pop_front();
                    // typed rows are checked against their typed result
                    if (tf)
                        want = typ;
                    if (event_valid !== want.ev)
                    begin
                        $error("event_valid expected %0d actual %0d", want.ev, event_valid);
                        failures++;
                    end
                    if (key_index !== want.key)
                    begin
                        $error("key_index expected %0d actual %0d", want.key, key_index);
                        failures++;
                    end
                    if (layer !== want.lay)
                    begin
                        $error("layer expected %0d actual %0d", want.lay, layer);
                        failures++;
                    end
                end
            end
            out_stall <= (rx_phase % 256) < 128 ? 1'b0 : (($urandom_range(0, 2) == 0)
                         || (rx_phase % 7 == 3));
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        scan_row_t   rows[$];
        scan_row_t   r;
        key_event_t  nil;
        logic [KEY_COUNT-1:0] b;
        int unsigned lk, other, len, phase;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        key_bits = '0;
        out_stall = 1'b0;
        failures = 0;
        idle_cycles = 0;
        rx_phase = 0;
        nil = '0;
        foreach (held_cnt[k])
            held_cnt[k] = 0;
        cur_layer = 0;
        p_deb = DEBOUNCE_RST;
        p_cancel = CANCEL_RST;
        p_delay = DELAY_RST;
        p_repeat = REPEAT_RST;
        p_hold = LAYER_HOLD_RST;
        p_pos = LAYER_POS_RST;
        cur_limit = int'(p_deb);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small ticks so holds, repeats and taps show quickly
        write_reg(CFG_DEBOUNCE, 60'd2);
        write_reg(CFG_CANCEL, 60'd6);
        write_reg(CFG_DELAY, 60'd0);
        write_reg(CFG_REPEAT, 60'd2);
        write_reg(CFG_LAYER_HOLD, {6{10'd4}});
        // layer keys 0..5 at positions 24..29
        write_reg(CFG_LAYER_POS, CFG_W'({5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24}));
        // empty scan after reset gives no event
        rows.push_back('{'0, 1'b1, nil});
        // plain key 0 held: debounce event on second scan, then repeats
        rows.push_back('{30'h1, 1'b1, nil});
        rows.push_back('{30'h1, 1'b1, fire_event(0, 0)});
        rows.push_back('{30'h1, 1'b0, nil});
        rows.push_back('{30'h1, 1'b0, nil});
        rows.push_back('{'0, 1'b0, nil});
        // highest key and all keys
        rows.push_back('{30'h2000_0000, 1'b0, nil});
        rows.push_back('{30'h2000_0000, 1'b0, nil});
        rows.push_back('{'0, 1'b0, nil});
        rows.push_back('{30'h3fff_ffff, 1'b0, nil});
        rows.push_back('{30'h3fff_ffff, 1'b0, nil});
        rows.push_back('{'0, 1'b0, nil});
        // layer key tap, then layer hold with another key
        rows.push_back('{30'h0100_0000, 1'b0, nil});
        rows.push_back('{30'h0100_0000, 1'b0, nil});
        rows.push_back('{'0, 1'b0, nil});
        rows.push_back('{30'h0100_0000, 1'b0, nil});
        rows.push_back('{30'h0100_0000, 1'b0, nil});
        rows.push_back('{30'h0100_0002, 1'b0, nil});
        rows.push_back('{30'h0100_0002, 1'b0, nil});
        rows.push_back('{30'h0100_0002, 1'b0, nil});
        rows.push_back('{30'h0000_0002, 1'b0, nil});
        rows.push_back('{'0, 1'b0, nil});
        foreach (rows[i])
        begin
            r = rows[i];
            send_scan(r.bits, r.typed, r.ev);
        end
        in_valid <= 1'b0;
        drain();

        // zero debounce, zero repeat, out of range layer position
        write_reg(CFG_DEBOUNCE, 60'd0);
        write_reg(CFG_REPEAT, 60'd0);
        write_reg(CFG_LAYER_POS, CFG_W'({5'd31, 5'd30, 5'd29, 5'd3, 5'd2, 5'd31}));
        for (int i = 0; i < 12; i++)
            send_scan(i < 5 ? 30'h4 : (i < 9 ? 30'h1c : 30'h0), 1'b0, nil);
        in_valid <= 1'b0;
        drain();

        // random phases with varied settings, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(CFG_DEBOUNCE, 60'd1);
                    write_reg(CFG_CANCEL, 60'd1);
                    write_reg(CFG_DELAY, 60'd1023);
                    write_reg(CFG_REPEAT, 60'd1);
                    write_reg(CFG_LAYER_HOLD, '1);
                    write_reg(CFG_LAYER_POS, '1);
                end
                5: begin
                    write_reg(CFG_DEBOUNCE, 60'd1023);
                    write_reg(CFG_CANCEL, 60'd1023);
                    write_reg(CFG_DELAY, 60'd0);
                    write_reg(CFG_REPEAT, 60'd1023);
                    write_reg(CFG_LAYER_HOLD, '0);
                    write_reg(CFG_LAYER_POS, CFG_W'({$urandom, $urandom}));
                end
                default: begin
                    write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 5)));
                    write_reg(CFG_CANCEL, CFG_W'($urandom_range(1, 20)));
                    write_reg(CFG_DELAY, CFG_W'($urandom_range(0, 6)));
                    write_reg(CFG_REPEAT, CFG_W'($urandom_range(0, 4)));
                    write_reg(CFG_LAYER_HOLD, CFG_W'({$urandom, $urandom}));
                    write_reg(CFG_LAYER_POS,
                              CFG_W'({5'($urandom_range(0, 31)), 5'($urandom_range(0, 29)),
                               5'($urandom_range(0, 29)), 5'($urandom_range(0, 29)),
                               5'($urandom_range(0, 29)), 5'($urandom_range(0, 29))}));
                end
            endcase
            len = 0;
            while (len < 250)
            begin
                // mostly: a held key group, sometimes with a layer key
                lk = p_pos[KEY_W*$urandom_range(0, 5) +: KEY_W];
                other = $urandom_range(0, KEY_COUNT - 1);
                b = '0;
                if ($urandom_range(0, 4) == 0)
                    b = KEY_COUNT'({$urandom, $urandom});
                else
                begin
                    if (lk < KEY_COUNT && $urandom_range(0, 1))
                        b[lk] = 1'b1;
                    b[other] = 1'b1;
                end
                repeat ($urandom_range(1, 12))
                begin
                    send_scan(b, 1'b0, nil);
                    len++;
                    if ($urandom_range(0, 3) == 0)
                        b[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
                    gap();
                end
                send_scan('0, 1'b0, nil);
                len++;
                gap();
            end
            // sender waits for every event
            in_valid <= 1'b0;
            drain();
        end

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
